>>> rtl/mpbm_pkg.sv
// Shared types and defaults for the multi-pattern byte matcher.
// Holds the item mode codes, the engine state type and the result record.
// No dependencies.
package mpbm_pkg;

    localparam int NODE_COUNT_DEF = 256;
    localparam int ALPHABET_DEF   = 128;

    typedef enum logic [1:0] {
        MODE_ADD     = 2'd0,
        MODE_BUILD   = 2'd1,
        MODE_SCAN    = 2'd2,
        MODE_RESTART = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_SCAN_FAIL,
        S_SCAN_END,
        S_B_CHILD,
        S_B_DESC,
        S_B_XFAIL,
        S_B_END,
        S_B_QRD,
        S_B_NFAIL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic valid;
        logic match;
        logic full;
    } t_res;

endpackage

>>> rtl/mpbm_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read.
// Used for the node tables of the matcher. No dependencies.
module mpbm_ram #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_wa,
    input  logic [WIDTH-1:0]     i_wd,
    input  logic [ADDR_BITS-1:0] i_ra,
    output logic [WIDTH-1:0]     o_rd
);

    logic [WIDTH-1:0] r_mem [2**ADDR_BITS];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_rd <= r_mem[i_ra];
    end

    assign o_rd = r_rd;

endmodule

>>> rtl/mpbm_engine.sv
// Sequencer of the matcher: child, failure, end-mark and queue tables in RAM,
// with add, build, scan and restart walks. Depends on mpbm_pkg and mpbm_ram.
module mpbm_engine
    import mpbm_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int ALPHABET   = ALPHABET_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_symbol,
    input  logic       i_last_in_pattern,
    input  logic       i_out_free,
    output t_res       o_res
);

    localparam int NB = $clog2(NODE_COUNT);
    localparam int SB = $clog2(ALPHABET);
    localparam int CB = NB + SB;

    t_state          r_state, n_state;
    logic [SB-1:0]   r_sym, n_sym;
    logic            r_last, n_last;
    logic [NB-1:0]   r_n, n_n;
    logic [NB-1:0]   r_fn, n_fn;
    logic [NB-1:0]   r_x, n_x;
    logic [NB-1:0]   r_c, n_c;
    logic [NB-1:0]   r_cur, n_cur;
    logic [NB-1:0]   r_ins, n_ins;
    logic [NB:0]     r_used, n_used;
    logic [NB:0]     r_head, n_head;
    logic [NB:0]     r_tail, n_tail;
    logic [SB-1:0]   r_s, n_s;
    logic [CB-1:0]   r_clr, n_clr;
    logic            r_match, n_match;
    logic            r_full, n_full;

    logic [CB-1:0] ch_ra, ch_wa;
    logic [NB-1:0] ch_wd, ch_rd;
    logic          ch_we;
    logic [NB-1:0] fl_ra, fl_wa, fl_wd, fl_rd;
    logic          fl_we;
    logic [NB-1:0] en_ra, en_wa;
    logic          en_we, en_wd, en_rd;
    logic [NB-1:0] q_ra, q_wa, q_wd, q_rd;
    logic          q_we;

    logic          w_accept;
    logic [SB-1:0] w_sym;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_sym = (int'(i_symbol) >= ALPHABET) ? '0 : i_symbol[SB-1:0];

    mpbm_ram #(.WIDTH(NB), .ADDR_BITS(CB)) u_child (
        .i_clk(i_clk), .i_we(ch_we), .i_wa(ch_wa), .i_wd(ch_wd),
        .i_ra(ch_ra), .o_rd(ch_rd)
    );
    mpbm_ram #(.WIDTH(NB), .ADDR_BITS(NB)) u_fail (
        .i_clk(i_clk), .i_we(fl_we), .i_wa(fl_wa), .i_wd(fl_wd),
        .i_ra(fl_ra), .o_rd(fl_rd)
    );
    mpbm_ram #(.WIDTH(1), .ADDR_BITS(NB)) u_end (
        .i_clk(i_clk), .i_we(en_we), .i_wa(en_wa), .i_wd(en_wd),
        .i_ra(en_ra), .o_rd(en_rd)
    );
    mpbm_ram #(.WIDTH(NB), .ADDR_BITS(NB)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_wa(q_wa), .i_wd(q_wd),
        .i_ra(q_ra), .o_rd(q_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_used  <= (NB+1)'(1);
            r_ins   <= '0;
            r_cur   <= '0;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_used  <= n_used;
            r_ins   <= n_ins;
            r_cur   <= n_cur;
            r_head  <= n_head;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym   <= n_sym;
        r_last  <= n_last;
        r_n     <= n_n;
        r_fn    <= n_fn;
        r_x     <= n_x;
        r_c     <= n_c;
        r_s     <= n_s;
        r_match <= n_match;
        r_full  <= n_full;
    end

    always_comb begin
        logic [NB-1:0] v_d;
        logic [NB-1:0] v_f;
        logic          v_adv;
        n_state = r_state;
        n_sym   = r_sym;
        n_last  = r_last;
        n_n     = r_n;
        n_fn    = r_fn;
        n_x     = r_x;
        n_c     = r_c;
        n_cur   = r_cur;
        n_ins   = r_ins;
        n_used  = r_used;
        n_head  = r_head;
        n_tail  = r_tail;
        n_s     = r_s;
        n_clr   = r_clr;
        n_match = r_match;
        n_full  = r_full;
        ch_ra = '0; ch_we = 1'b0; ch_wa = '0; ch_wd = '0;
        fl_ra = '0; fl_we = 1'b0; fl_wa = '0; fl_wd = '0;
        en_ra = '0; en_we = 1'b0; en_wa = '0; en_wd = 1'b0;
        q_ra  = '0; q_we  = 1'b0; q_wa  = '0; q_wd  = '0;
        v_d   = ch_rd;
        v_f   = '0;
        v_adv = 1'b0;

        case (r_state)
            S_CLEAR: begin
                // The failure and end tables are swept many times over; harmless.
                ch_we = 1'b1; ch_wa = r_clr;
                fl_we = 1'b1; fl_wa = r_clr[NB-1:0];
                en_we = 1'b1; en_wa = r_clr[NB-1:0];
                n_clr = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_sym   = w_sym;
                    n_last  = i_last_in_pattern;
                    n_match = 1'b0;
                    n_full  = 1'b0;
                    case (t_mode'(i_mode))
                        MODE_ADD: begin
                            ch_ra   = {r_ins, w_sym};
                            n_state = S_ADD;
                        end
                        MODE_BUILD: begin
                            n_n = '0; n_fn = '0; n_s = '0;
                            n_head = '0; n_tail = '0;
                            ch_ra   = '0;
                            n_state = S_B_CHILD;
                        end
                        MODE_SCAN: begin
                            n_x     = r_cur;
                            ch_ra   = {r_cur, w_sym};
                            n_state = S_SCAN;
                        end
                        MODE_RESTART: begin
                            n_cur   = '0;
                            n_state = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_ADD: begin
                if (v_d == '0) begin
                    if (r_used < (NB+1)'(NODE_COUNT)) begin
                        v_d    = r_used[NB-1:0];
                        ch_we  = 1'b1;
                        ch_wa  = {r_ins, r_sym};
                        ch_wd  = v_d;
                        n_used = r_used + 1'b1;
                    end else begin
                        n_full = 1'b1;
                    end
                end
                if (n_full) begin
                    if (r_last) begin
                        n_ins = '0;
                    end
                end else if (r_last) begin
                    en_we = 1'b1; en_wa = v_d; en_wd = 1'b1;
                    n_ins = '0;
                end else begin
                    n_ins = v_d;
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (v_d != '0) begin
                    n_c     = v_d;
                    en_ra   = v_d;
                    n_state = S_SCAN_END;
                end else if (r_x == '0) begin
                    n_cur   = '0;
                    n_state = S_DONE;
                end else begin
                    fl_ra   = r_x;
                    n_state = S_SCAN_FAIL;
                end
            end
            S_SCAN_FAIL: begin
                n_x     = fl_rd;
                ch_ra   = {fl_rd, r_sym};
                n_state = S_SCAN;
            end
            S_SCAN_END: begin
                if (en_rd) begin
                    n_match = 1'b1;
                    n_cur   = '0;
                end else begin
                    n_cur = r_c;
                end
                n_state = S_DONE;
            end
            S_B_CHILD: begin
                if (v_d != '0) begin
                    n_c     = v_d;
                    n_x     = r_fn;
                    ch_ra   = {r_fn, r_s};
                    n_state = S_B_DESC;
                end else begin
                    v_adv = 1'b1;
                end
            end
            S_B_DESC: begin
                if (v_d != '0 || r_x == '0) begin
                    // A root child would otherwise fail to itself.
                    v_f    = (v_d == r_c) ? '0 : v_d;
                    fl_we  = 1'b1; fl_wa = r_c; fl_wd = v_f;
                    q_we   = 1'b1; q_wa = r_tail[NB-1:0]; q_wd = r_c;
                    n_tail = r_tail + 1'b1;
                    en_ra  = v_f;
                    n_state = S_B_END;
                end else begin
                    fl_ra   = r_x;
                    n_state = S_B_XFAIL;
                end
            end
            S_B_XFAIL: begin
                n_x     = fl_rd;
                ch_ra   = {fl_rd, r_s};
                n_state = S_B_DESC;
            end
            S_B_END: begin
                if (en_rd) begin
                    en_we = 1'b1; en_wa = r_c; en_wd = 1'b1;
                end
                v_adv = 1'b1;
            end
            S_B_QRD: begin
                n_n     = q_rd;
                fl_ra   = q_rd;
                n_state = S_B_NFAIL;
            end
            S_B_NFAIL: begin
                n_fn    = fl_rd;
                n_s     = '0;
                ch_ra   = {r_n, {SB{1'b0}}};
                n_state = S_B_CHILD;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Next symbol of the current node, else the next node off the queue, else done.
        if (v_adv) begin
            if (r_s != SB'(ALPHABET - 1)) begin
                n_s     = r_s + 1'b1;
                ch_ra   = {r_n, n_s};
                n_state = S_B_CHILD;
            end else if (r_head < r_tail) begin
                q_ra    = r_head[NB-1:0];
                n_head  = r_head + 1'b1;
                n_state = S_B_QRD;
            end else begin
                n_state = S_DONE;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res.valid = (r_state == S_DONE);
    assign o_res.match = r_match;
    assign o_res.full  = r_full;

    a_full_means_used_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.full) |-> (r_used == (NB+1)'(NODE_COUNT)))
        else $error("table full reported with free nodes");
    a_match_returns_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.match) |-> (r_cur == '0))
        else $error("match left scan away from root");
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |-> (r_head <= r_tail && r_tail < (NB+1)'(NODE_COUNT)))
        else $error("build queue overrun");
    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_out_free) |=> (r_state == S_IDLE))
        else $error("result not handed over");

endmodule

>>> rtl/multi_pattern_byte_matcher.sv
// Top level of the multi-pattern byte matcher: engine plus output register.
// Depends on mpbm_pkg and mpbm_engine.
//
// Input beats carry a mode (add pattern byte, build failure links, scan byte,
// restart scan), a symbol and a last-in-pattern flag; every input beat gives
// exactly one output beat with match and table_full.
// Items are taken one at a time; o_in_stall is high while one is in work.
// States per item: add S_ADD, S_DONE; restart S_DONE; scan S_SCAN (with
// S_SCAN_FAIL, S_SCAN per failure link), S_SCAN_END if a child is found,
// S_DONE. Build: S_B_CHILD per node and symbol, S_B_DESC, S_B_END per child
// (S_B_XFAIL, S_B_DESC per link), S_B_QRD, S_B_NFAIL per queued node, S_DONE.
// The next item is accepted as soon as the result sits in the output
// register, so a stalled receiver holds up the block only once that register
// is full and a further result is ready.
// After reset the child, failure and end tables are cleared one child entry
// a cycle, with o_in_stall high.
module multi_pattern_byte_matcher
    import mpbm_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int ALPHABET   = ALPHABET_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_symbol,
    input  logic       i_last_in_pattern,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_match,
    output logic       o_table_full
);

    t_res res;
    logic w_free;
    logic r_out_valid;
    logic r_match;
    logic r_full;

    assign w_free = !r_out_valid || !i_out_stall;

    mpbm_engine #(.NODE_COUNT(NODE_COUNT), .ALPHABET(ALPHABET)) u_engine (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_mode(i_mode),
        .i_symbol(i_symbol),
        .i_last_in_pattern(i_last_in_pattern),
        .i_out_free(w_free),
        .o_res(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_free) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free && res.valid) begin
            r_match <= res.match;
            r_full  <= res.full;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_match      = r_match;
    assign o_table_full = r_full;

endmodule
